[rtl/mdcd_pkg.sv]
// shared types, constants and helpers for the mecanum drive command decoder
package mdcd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned SpeedW   = 12;

  localparam logic [ByteW-1:0] HeaderReset  = 8'hAA;
  localparam logic [ByteW-1:0] FooterReset  = 8'h55;
  localparam logic [TimeW-1:0] TimeoutReset = 16'd500;
  localparam logic [ByteW-1:0] CenterReset  = 8'd127;
  localparam logic [ByteW-1:0] PwmMax       = 8'hFF;
  localparam logic [TimeW-1:0] ElapsedMax   = 16'hFFFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEADER  = 2'd0,
    REG_FOOTER  = 2'd1,
    REG_TIMEOUT = 2'd2,
    REG_CENTER  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef struct packed {
    logic             command;
    logic [ByteW-1:0] rx_byte;
  } mdcd_in_t;

  typedef struct packed {
    logic             dir_left_front;
    logic [ByteW-1:0] pwm_left_front;
    logic             dir_right_front;
    logic [ByteW-1:0] pwm_right_front;
    logic             dir_left_back;
    logic [ByteW-1:0] pwm_left_back;
    logic             dir_right_back;
    logic [ByteW-1:0] pwm_right_back;
    logic             is_timeout_stop;
  } mdcd_out_t;

  typedef struct packed {
    logic             dir;
    logic [ByteW-1:0] pwm;
  } wheel_t;

  function automatic wheel_t wheel_drive(input logic signed [SpeedW-1:0] s);
    logic signed [SpeedW-1:0] mag;
    wheel_t w;
    mag   = s[SpeedW-1] ? -s : s;
    w.dir = !s[SpeedW-1] && (s != '0);
    w.pwm = (mag > $signed({{(SpeedW-ByteW){1'b0}}, PwmMax})) ? PwmMax : mag[ByteW-1:0];
    return w;
  endfunction

endpackage

[rtl/mdcd_wheel_mix.sv]
// centers the three axis bytes and mixes them into four wheel drives
module mdcd_wheel_mix (
  input  logic [mdcd_pkg::ByteW-1:0] fwd_i,
  input  logic [mdcd_pkg::ByteW-1:0] strafe_i,
  input  logic [mdcd_pkg::ByteW-1:0] rot_i,
  input  logic [mdcd_pkg::ByteW-1:0] center_i,
  output mdcd_pkg::mdcd_out_t        res_o
);
  import mdcd_pkg::*;

  localparam int unsigned PadW = SpeedW - ByteW;

  logic signed [SpeedW-1:0] x, y, r;
  logic signed [SpeedW-1:0] s_lf, s_rf, s_lb, s_rb;
  wheel_t w_lf, w_rf, w_lb, w_rb;

  assign x = ($signed({{PadW{1'b0}}, fwd_i})    - $signed({{PadW{1'b0}}, center_i})) <<< 1;
  assign y = ($signed({{PadW{1'b0}}, strafe_i}) - $signed({{PadW{1'b0}}, center_i})) <<< 1;
  assign r = ($signed({{PadW{1'b0}}, rot_i})    - $signed({{PadW{1'b0}}, center_i})) <<< 1;

  assign s_lf = x + y + r;
  assign s_rf = x - y - r;
  assign s_lb = x - y + r;
  assign s_rb = x + y - r;

  assign w_lf = wheel_drive(s_lf);
  assign w_rf = wheel_drive(s_rf);
  assign w_lb = wheel_drive(s_lb);
  assign w_rb = wheel_drive(s_rb);

  always_comb begin
    res_o.dir_left_front  = w_lf.dir;
    res_o.pwm_left_front  = w_lf.pwm;
    res_o.dir_right_front = w_rf.dir;
    res_o.pwm_right_front = w_rf.pwm;
    res_o.dir_left_back   = w_lb.dir;
    res_o.pwm_left_back   = w_lb.pwm;
    res_o.dir_right_back  = w_rb.dir;
    res_o.pwm_right_back  = w_rb.pwm;
    res_o.is_timeout_stop = 1'b0;
  end

endmodule

[rtl/mecanum_drive_command_decoder.sv]
// top level: frame parser, watchdog and wheel command output register
//
// channel | direction | signals                              | transfer when
// in      | in        | in_valid_i, in_stall_o, in_data_i    | valid high, stall low
// out     | out       | out_valid_o, out_stall_i, out_data_o | valid high, stall low
// cfg     | in        | cfg_we_i, cfg_idx_i, cfg_wdata_i     | write enable high
//
// one item per cycle while the input is not stalled; an item is held in the input
// register and its result, if any, is registered in the output register as it moves on
// reset clears the frame parser, watchdog, valids and registers to defaults
// a stalled output holds the result; input stalls only when the input
// register holds an item that cannot move on
module mecanum_drive_command_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mdcd_pkg::mdcd_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mdcd_pkg::mdcd_out_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [mdcd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mdcd_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import mdcd_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_FWD    = 3'd1,
    PH_STRAFE = 3'd2,
    PH_ROT    = 3'd3,
    PH_FOOTER = 3'd4
  } phase_e;

  logic [ByteW-1:0] header_q, footer_q, center_q;
  logic [TimeW-1:0] timeout_q;

  logic      s1_vld_q;
  mdcd_in_t  s1_q;
  logic      out_vld_q;
  mdcd_out_t out_q;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] fwd_q, strafe_q, rot_q;
  logic [TimeW-1:0] elapsed_q, elapsed_d;
  logic             stop_sent_q, stop_sent_d;

  logic      out_free, s1_go, in_xfer;
  logic      is_tick, fire, frame_ok;
  mdcd_out_t mix_res, stop_res;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= HeaderReset;
      footer_q  <= FooterReset;
      timeout_q <= TimeoutReset;
      center_q  <= CenterReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_HEADER:  header_q  <= cfg_wdata_i[ByteW-1:0];
        REG_FOOTER:  footer_q  <= cfg_wdata_i[ByteW-1:0];
        REG_TIMEOUT: timeout_q <= cfg_wdata_i[TimeW-1:0];
        REG_CENTER:  center_q  <= cfg_wdata_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_vld_q || !out_stall_i;
  assign s1_go      = s1_vld_q && out_free;
  assign in_stall_o = s1_vld_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign is_tick  = (s1_q.command == CMD_TICK);
  assign fire     = is_tick && (elapsed_q >= timeout_q) && !stop_sent_q;
  assign frame_ok = !is_tick && (phase_q == PH_FOOTER) && (s1_q.rx_byte == footer_q);

  mdcd_wheel_mix u_mix (
    .fwd_i    (fwd_q),
    .strafe_i (strafe_q),
    .rot_i    (rot_q),
    .center_i (center_q),
    .res_o    (mix_res)
  );

  always_comb begin
    stop_res                 = '0;
    stop_res.is_timeout_stop = 1'b1;
  end

  always_comb begin
    phase_d     = phase_q;
    elapsed_d   = elapsed_q;
    stop_sent_d = stop_sent_q;
    if (is_tick) begin
      if (elapsed_q != ElapsedMax) elapsed_d = elapsed_q + TimeW'(1);
      if (fire) stop_sent_d = 1'b1;
    end else begin
      unique case (phase_q)
        PH_FWD:    phase_d = PH_STRAFE;
        PH_STRAFE: phase_d = PH_ROT;
        PH_ROT:    phase_d = PH_FOOTER;
        PH_FOOTER: begin
          phase_d = PH_HEADER;
          if (frame_ok) begin
            elapsed_d   = '0;
            stop_sent_d = 1'b0;
          end
        end
        default: phase_d = (s1_q.rx_byte == header_q) ? PH_FWD : PH_HEADER;
      endcase
    end
  end

  // input register, parser state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s1_q        <= '0;
      out_vld_q   <= 1'b0;
      out_q       <= '0;
      phase_q     <= PH_HEADER;
      fwd_q       <= '0;
      strafe_q    <= '0;
      rot_q       <= '0;
      elapsed_q   <= '0;
      stop_sent_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_vld_q <= 1'b1;
        s1_q     <= in_data_i;
      end else if (s1_go) begin
        s1_vld_q <= 1'b0;
      end
      if (out_free) begin
        out_vld_q <= s1_go && (fire || frame_ok);
      end
      if (s1_go && fire) begin
        out_q <= stop_res;
      end else if (s1_go && frame_ok) begin
        out_q <= mix_res;
      end
      if (s1_go) begin
        phase_q     <= phase_d;
        elapsed_q   <= elapsed_d;
        stop_sent_q <= stop_sent_d;
        if (!is_tick) begin
          if (phase_q == PH_FWD)    fwd_q    <= s1_q.rx_byte;
          if (phase_q == PH_STRAFE) strafe_q <= s1_q.rx_byte;
          if (phase_q == PH_ROT)    rot_q    <= s1_q.rx_byte;
        end
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_fire_marks_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && fire |=> stop_sent_q && out_vld_q && out_q.is_timeout_stop)
    else $error("stop not recorded after watchdog fire");

  a_frame_clears_watchdog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && frame_ok |=> elapsed_q == '0 && !stop_sent_q && out_vld_q)
    else $error("good frame did not reset watchdog");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_vld_q && out_vld_q)
    else $error("input stalled with nothing held");

  a_stop_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.is_timeout_stop |->
      out_q.pwm_left_front == '0 && out_q.pwm_right_front == '0 &&
      out_q.pwm_left_back == '0 && out_q.pwm_right_back == '0 &&
      !out_q.dir_left_front && !out_q.dir_right_front &&
      !out_q.dir_left_back && !out_q.dir_right_back)
    else $error("watchdog stop carries nonzero drive");

endmodule

[bench/mdcd_checker.sv]
`timescale 1ns / 1ps
// checker for the mecanum drive command decoder: predicts wheel commands and compares them
module mdcd_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  mdcd_pkg::mdcd_in_t            in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  mdcd_pkg::mdcd_out_t           out_data_i,
  input  logic                          cfg_we_i,
  input  logic [mdcd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mdcd_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int                            pending_o,
  output int                            fail_count_o
);
  import mdcd_pkg::*;

  typedef enum logic [2:0] {
    PS_SYNC,
    PS_FWD,
    PS_SIDE,
    PS_SPIN,
    PS_CLOSE
  } parse_state_e;

  logic [ByteW-1:0] header_cfg;
  logic [ByteW-1:0] footer_cfg;
  logic [TimeW-1:0] timeout_cfg;
  logic [ByteW-1:0] center_cfg;

  parse_state_e     parse_state;
  logic [ByteW-1:0] forward_q;
  logic [ByteW-1:0] strafe_q;
  logic [ByteW-1:0] rotate_q;
  logic [TimeW-1:0] ms_since_frame;
  logic             stop_issued;

  mdcd_out_t wheel_cmds_expected[$];
  mdcd_out_t wheel_cmd;
  mdcd_out_t oldest_cmd;
  wheel_t    lf, rf, lb, rb;
  int        fwd_speed, strafe_speed, rot_speed;
  logic      stop_due;
  int        mismatches;

  function automatic int axis_speed(input logic [ByteW-1:0] b, input logic [ByteW-1:0] c);
    return (int'(b) - int'(c)) * 2;
  endfunction

  function automatic wheel_t drive_wheel(input int s);
    wheel_t w;
    int     mag;
    mag   = (s < 0) ? -s : s;
    w.dir = (s > 0);
    w.pwm = (mag > 255) ? PwmMax : 8'(mag);
    return w;
  endfunction

  task automatic check_field(input string name, input logic [ByteW-1:0] exp_v,
                             input logic [ByteW-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t mismatch %s: expected %0h got %0h", $realtime, name, exp_v, act_v);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_cfg     = HeaderReset;
      footer_cfg     = FooterReset;
      timeout_cfg    = TimeoutReset;
      center_cfg     = CenterReset;
      parse_state    = PS_SYNC;
      forward_q      = '0;
      strafe_q       = '0;
      rotate_q       = '0;
      ms_since_frame = '0;
      stop_issued    = 1'b0;
      wheel_cmds_expected.delete();
      mismatches     = 0;
    end else begin
      // output transfer first: it always belongs to an earlier input
      if (out_valid_i && !out_stall_i) begin
        if (wheel_cmds_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t mismatch: unexpected result %0h", $realtime, out_data_i);
          end
        end else begin
          oldest_cmd = wheel_cmds_expected.pop_front();
          check_field("dir_left_front", oldest_cmd.dir_left_front, out_data_i.dir_left_front);
          check_field("pwm_left_front", oldest_cmd.pwm_left_front, out_data_i.pwm_left_front);
          check_field("dir_right_front", oldest_cmd.dir_right_front,
                      out_data_i.dir_right_front);
          check_field("pwm_right_front", oldest_cmd.pwm_right_front,
                      out_data_i.pwm_right_front);
          check_field("dir_left_back", oldest_cmd.dir_left_back, out_data_i.dir_left_back);
          check_field("pwm_left_back", oldest_cmd.pwm_left_back, out_data_i.pwm_left_back);
          check_field("dir_right_back", oldest_cmd.dir_right_back, out_data_i.dir_right_back);
          check_field("pwm_right_back", oldest_cmd.pwm_right_back, out_data_i.pwm_right_back);
          check_field("is_timeout_stop", oldest_cmd.is_timeout_stop,
                      out_data_i.is_timeout_stop);
        end
      end

      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_HEADER:  header_cfg  = cfg_wdata_i[ByteW-1:0];
          REG_FOOTER:  footer_cfg  = cfg_wdata_i[ByteW-1:0];
          REG_TIMEOUT: timeout_cfg = cfg_wdata_i;
          REG_CENTER:  center_cfg  = cfg_wdata_i[ByteW-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.command == CMD_TICK) begin
          stop_due = (ms_since_frame >= timeout_cfg) && !stop_issued;
          if (ms_since_frame != ElapsedMax) ms_since_frame++;
          if (stop_due) begin
            stop_issued = 1'b1;
            wheel_cmd = '0;
            wheel_cmd.is_timeout_stop = 1'b1;
            wheel_cmds_expected.push_back(wheel_cmd);
          end
        end else begin
          case (parse_state)
            PS_FWD: begin
              forward_q   = in_data_i.rx_byte;
              parse_state = PS_SIDE;
            end
            PS_SIDE: begin
              strafe_q    = in_data_i.rx_byte;
              parse_state = PS_SPIN;
            end
            PS_SPIN: begin
              rotate_q    = in_data_i.rx_byte;
              parse_state = PS_CLOSE;
            end
            PS_CLOSE: begin
              parse_state = PS_SYNC;
              if (in_data_i.rx_byte == footer_cfg) begin
                fwd_speed    = axis_speed(forward_q, center_cfg);
                strafe_speed = axis_speed(strafe_q, center_cfg);
                rot_speed    = axis_speed(rotate_q, center_cfg);
                lf = drive_wheel(fwd_speed + strafe_speed + rot_speed);
                rf = drive_wheel(fwd_speed - strafe_speed - rot_speed);
                lb = drive_wheel(fwd_speed - strafe_speed + rot_speed);
                rb = drive_wheel(fwd_speed + strafe_speed - rot_speed);
                wheel_cmd.dir_left_front  = lf.dir;
                wheel_cmd.pwm_left_front  = lf.pwm;
                wheel_cmd.dir_right_front = rf.dir;
                wheel_cmd.pwm_right_front = rf.pwm;
                wheel_cmd.dir_left_back   = lb.dir;
                wheel_cmd.pwm_left_back   = lb.pwm;
                wheel_cmd.dir_right_back  = rb.dir;
                wheel_cmd.pwm_right_back  = rb.pwm;
                wheel_cmd.is_timeout_stop = 1'b0;
                wheel_cmds_expected.push_back(wheel_cmd);
                ms_since_frame = '0;
                stop_issued    = 1'b0;
              end
            end
            default: begin
              parse_state = (in_data_i.rx_byte == header_cfg) ? PS_FWD : PS_SYNC;
            end
          endcase
        end
      end
    end
    pending_o    <= wheel_cmds_expected.size();
    fail_count_o <= mismatches;
  end

endmodule

[bench/mecanum_drive_command_decoder_test.sv]
`timescale 1ns / 1ps
// testbench top for the mecanum drive command decoder: stimulus, idling and verdict
module mecanum_drive_command_decoder_test;
  import mdcd_pkg::*;

  localparam int HoldCycles = 80;
  localparam int PhaseItems = 640;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  mdcd_in_t            in_data;
  logic                out_valid;
  logic                out_stall;
  mdcd_out_t           out_data;
  logic                cfg_we;
  cfg_reg_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  int                  pending;
  int                  fail_count;

  int               send_idle_pct;
  int               recv_stall_pct;
  logic             hold_off_req;
  logic [ByteW-1:0] cur_header;
  logic [ByteW-1:0] cur_footer;
  logic [ByteW-1:0] cur_center;

  mecanum_drive_command_decoder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  mdcd_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #12_000_000;
    $display("FAIL");
    $finish;
  end

  // receiver: random stall, plus one long hold-off on request
  initial begin
    out_stall    = 1'b0;
    hold_off_req = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req <= 1'b0;
        out_stall    <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic send_item(input cmd_e cmd, input logic [ByteW-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data.command <= cmd;
    in_data.rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 8'($urandom));
  endtask

  task automatic send_frame(input logic [ByteW-1:0] hdr, input logic [ByteW-1:0] fwd,
                            input logic [ByteW-1:0] strafe, input logic [ByteW-1:0] rot,
                            input logic [ByteW-1:0] ftr);
    send_item(CMD_BYTE, hdr);
    send_item(CMD_BYTE, fwd);
    send_item(CMD_BYTE, strafe);
    send_item(CMD_BYTE, rot);
    send_item(CMD_BYTE, ftr);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    repeat (3) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input logic [ByteW-1:0] hdr, input logic [ByteW-1:0] ftr,
                              input logic [TimeW-1:0] tmo, input logic [ByteW-1:0] ctr);
    logic [CfgDataW-1:0] vals [4];
    wait_idle();
    // upper bits of the byte registers carry junk on purpose
    vals[REG_HEADER]  = {8'($urandom), hdr};
    vals[REG_FOOTER]  = {8'($urandom), ftr};
    vals[REG_TIMEOUT] = tmo;
    vals[REG_CENTER]  = {8'($urandom), ctr};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= cfg_reg_e'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we     <= 1'b0;
    cur_header = hdr;
    cur_footer = ftr;
    cur_center = ctr;
  endtask

  function automatic logic [ByteW-1:0] pick_axis();
    int t;
    if ($urandom_range(0, 1) == 0) return 8'($urandom);
    t = int'(cur_center) + int'($urandom_range(0, 60)) - 30;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return 8'(t);
  endfunction

  task automatic random_traffic(input int n_items);
    int               sent;
    int               kind;
    int               burst;
    logic [ByteW-1:0] bad_footer;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        send_frame(cur_header, pick_axis(), pick_axis(), pick_axis(), cur_footer);
        sent += 5;
      end else if (kind < 72) begin
        // broken frame: possibly short, closed by a wrong footer
        send_item(CMD_BYTE, cur_header);
        burst = $urandom_range(0, 3);
        for (int i = 0; i < burst; i++) send_item(CMD_BYTE, pick_axis());
        bad_footer = 8'($urandom);
        if (bad_footer == cur_footer) bad_footer = ~bad_footer;
        send_item(CMD_BYTE, bad_footer);
        sent += burst + 2;
      end else if (kind < 80) begin
        send_item(CMD_BYTE, 8'($urandom));
        sent++;
      end else begin
        burst = (kind < 97) ? $urandom_range(1, 8) : $urandom_range(20, 60);
        for (int i = 0; i < burst; i++) send_tick();
        sent += burst;
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_HEADER;
    cfg_wdata      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur_header     = HeaderReset;
    cur_footer     = FooterReset;
    cur_center     = CenterReset;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: ignored noise, saturation both ways, zero speed,
    // mixed signs, wrong footer, tick without timeout
    send_item(CMD_BYTE, 8'h00);
    send_frame(8'hAA, 8'hFF, 8'hFF, 8'hFF, 8'h55);
    send_frame(8'hAA, 8'h00, 8'h00, 8'h00, 8'h55);
    send_frame(8'hAA, 8'd127, 8'd127, 8'd127, 8'h55);
    send_frame(8'hAA, 8'd200, 8'd60, 8'd140, 8'h55);
    send_frame(8'hAA, 8'd1, 8'd2, 8'd3, 8'h54);
    send_item(CMD_TICK, 8'hFF);

    // zero timeout: stop on the first tick only, rearmed by a good frame
    apply_config(8'hAA, 8'h55, 16'd0, 8'd127);
    send_tick();
    send_tick();
    send_frame(8'hAA, 8'd130, 8'd120, 8'd127, 8'h55);
    send_tick();

    apply_config(8'($urandom), 8'($urandom), 16'($urandom_range(1, 40)), 8'($urandom));
    send_idle_pct  = 27;
    recv_stall_pct = 64;
    hold_off_req  <= 1'b1;
    random_traffic(PhaseItems);

    apply_config(8'h00, 8'hFF, 16'd1, 8'h00);
    send_idle_pct  = 64;
    recv_stall_pct = 27;
    random_traffic(PhaseItems);

    apply_config(8'hFF, 8'h00, 16'd12, 8'hFF);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req  <= 1'b1;
    random_traffic(PhaseItems);

    wait_idle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[mecanum_drive_command_decoder.f]
rtl/mdcd_pkg.sv
rtl/mdcd_wheel_mix.sv
rtl/mecanum_drive_command_decoder.sv
bench/mdcd_checker.sv
bench/mecanum_drive_command_decoder_test.sv
